>>> rtl/core/rtbp_pkg.sv
// shared constants and control types for the raster to block padder
package rtbp_pkg;

  localparam int BLK           = 8;
  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // register select from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic       ld_out;
    logic [2:0] y;
  } rtbp_cmd_t;

  typedef struct packed {
    logic blk_done;
    logic out_free;
  } rtbp_stat_t;

endpackage

>>> rtl/core/rtbp_ctrl.sv
// controller: pixel intake and block row read sequencing
module rtbp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtbp_pkg::rtbp_stat_t stat,
  output rtbp_pkg::rtbp_cmd_t  cmd
);
  import rtbp_pkg::*;

  localparam logic [1:0] S_IN = 2'd0;
  localparam logic [1:0] S_RD = 2'd1;
  localparam logic [1:0] S_WB = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] y_r, y_nxt;

  assign in_stall = (state_r != S_IN);

  always_comb begin
    state_nxt  = state_r;
    y_nxt      = y_r;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.ld_out = 1'b0;
    cmd.y      = y_r;
    case (state_r)
      S_IN: begin
        cmd.accept = in_valid;
        if (in_valid && stat.blk_done) begin
          state_nxt = S_RD;
          y_nxt     = 3'd0;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        // read data waits in the lane registers until the output frees up
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          if (y_r == 3'd7) begin
            state_nxt = S_IN;
          end else begin
            y_nxt     = y_r + 3'd1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      y_r     <= 3'd0;
    end else begin
      state_r <= state_nxt;
      y_r     <= y_nxt;
    end
  end

endmodule

>>> rtl/core/rtbp_dpath.sv
// datapath: counters, eight-lane line store, edge padding and output register
module rtbp_dpath #(
  parameter int MAX_WIDTH = rtbp_pkg::DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [11:0]          cfg_width,
  input  logic [15:0]          cfg_height,
  input  logic [7:0]           in_pixel,
  input  rtbp_pkg::rtbp_cmd_t  cmd,
  output rtbp_pkg::rtbp_stat_t stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [63:0]          out_row_pixels,
  output logic [2:0]           out_row_in_block,
  output logic [7:0]           out_block_column,
  output logic [12:0]          out_block_row,
  output logic                 out_last_of_block,
  output logic                 out_last_of_image
);
  import rtbp_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int BW    = (CW > 3) ? CW - 3 : 1;
  localparam int AW    = 3 + BW;
  localparam int DEPTH = 1 << AW;
  localparam int CMPW  = ((CW > 12) ? CW : 12) + 1;

  logic [CW-1:0] col_r;
  logic [15:0]   row_r;
  logic [11:0]   w_eff;
  logic [15:0]   h_eff;
  logic          row_end, img_end, col_last, row_last;
  logic [2:0]    srow;
  logic [BW-1:0] blk;

  assign w_eff = (cfg_width == 12'd0) ? 12'd1 : cfg_width;
  assign h_eff = (cfg_height == 16'd0) ? 16'd1 : cfg_height;
  // a width beyond the store behaves as the store width
  assign row_end  = ((CMPW'(col_r) + CMPW'(1)) >= CMPW'(w_eff)) ||
                    (col_r == CW'(MAX_WIDTH - 1));
  assign img_end  = ((17'(row_r) + 17'd1) >= 17'(h_eff));
  assign col_last = (col_r[2:0] == 3'd7) || row_end;
  assign row_last = (row_r[2:0] == 3'd7) || img_end;
  assign srow     = row_r[2:0];
  assign blk      = BW'(col_r >> 3);

  assign stat.blk_done = col_last && row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= img_end ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // block context captured with the completing pixel
  logic [BW-1:0] blk_r;
  logic [2:0]    lastx_r;
  logic [2:0]    srow_r;
  logic [12:0]   brow_r;
  logic          img_last_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.blk_done) begin
      blk_r      <= blk;
      lastx_r    <= col_r[2:0];
      srow_r     <= srow;
      brow_r     <= row_r[15:3];
      img_last_r <= row_end && img_end;
    end
  end

  // line store: one lane per pixel position within a block row
  logic [2:0]    sy;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_q [BLK];

  assign sy      = (cmd.y < srow_r) ? cmd.y : srow_r;
  assign wr_addr = {srow, blk};
  assign rd_addr = {sy, blk_r};

  for (genvar l = 0; l < BLK; l++) begin : g_lane
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (cmd.accept && (col_r[2:0] == 3'(l))) begin
        mem[wr_addr] <= in_pixel;
      end
      if (cmd.rd_en) begin
        rd_q[l] <= mem[rd_addr];
      end
    end
  end

  // right edge padding repeats the last valid column
  logic [63:0] padded;
  always_comb begin
    for (int x = 0; x < BLK; x++) begin
      padded[8*x +: 8] = (3'(x) < lastx_r) ? rd_q[x] : rd_q[lastx_r];
    end
  end

  logic [31:0] blk_ext;
  assign blk_ext = 32'(blk_r);

  logic        out_valid_r;
  logic [63:0] row_pixels_r;
  logic [2:0]  row_in_block_r;
  logic [7:0]  block_column_r;
  logic [12:0] block_row_r;
  logic        last_of_block_r, last_of_image_r;

  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      row_pixels_r    <= padded;
      row_in_block_r  <= cmd.y;
      block_column_r  <= blk_ext[7:0];
      block_row_r     <= brow_r;
      last_of_block_r <= (cmd.y == 3'd7);
      last_of_image_r <= (cmd.y == 3'd7) && img_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_pixels    = row_pixels_r;
  assign out_row_in_block  = row_in_block_r;
  assign out_block_column  = block_column_r;
  assign out_block_row     = block_row_r;
  assign out_last_of_block = last_of_block_r;
  assign out_last_of_image = last_of_image_r;

endmodule

>>> rtl/core/raster_to_8x8_block_padder_top.sv
// top level: configuration registers, controller and datapath
// a pixel that completes no block is taken without a stall; the pixel that completes a block
// is followed by in_stall high while each of its eight block rows is read from the line store
// and then loaded into the output register, longer while out_stall holds the output
// the first result row follows the completing pixel through the line store read and the output register load
// reset clears the counters, the controller and out_valid; the line store is not cleared
module raster_to_8x8_block_padder_top #(
  parameter int MAX_WIDTH = rtbp_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_row_pixels,
  output logic [2:0]  out_row_in_block,
  output logic [7:0]  out_block_column,
  output logic [12:0] out_block_row,
  output logic        out_last_of_block,
  output logic        out_last_of_image
);
  import rtbp_pkg::*;

  logic [11:0] width_r;
  logic [15:0] height_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[11:0];
      end else begin
        height_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  rtbp_cmd_t  cmd;
  rtbp_stat_t stat;

  rtbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtbp_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_width         (width_r),
    .cfg_height        (height_r),
    .in_pixel          (in_pixel),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_row_pixels    (out_row_pixels),
    .out_row_in_block  (out_row_in_block),
    .out_block_column  (out_block_column),
    .out_block_row     (out_block_row),
    .out_last_of_block (out_last_of_block),
    .out_last_of_image (out_last_of_image)
  );

endmodule

>>> tb/sv/raster_to_8x8_block_padder_top_tb.sv
// self-checking testbench for the raster to 8x8 block padder: predictor, random stalls, apb setup
module raster_to_8x8_block_padder_top_tb;
  import rtbp_pkg::*;

  localparam int STORE_W     = DEF_MAX_WIDTH;
  localparam int STORE_SIZE  = BLK * STORE_W;
  localparam int RANDOM_ITEMS = 128;
  localparam int SETTLE      = 24;       // completing pixel holds in_stall while its block rows are read out
  localparam int LIMIT       = 1000000;
  localparam int N_DIRECTED  = 18;

  localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

  typedef struct packed {
    logic [63:0] pixels;
    logic [2:0]  row_in_block;
    logic [7:0]  block_column;
    logic [12:0] block_row;
    logic        last_of_block;
    logic        last_of_image;
  } block_row_t;

  typedef struct packed {
    logic        resize;
    logic [11:0] w;
    logic [15:0] h;
    logic [7:0]  pixel;
    logic        flat;   // 1x1 image: every block row repeats the pixel
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_row_pixels;
  logic [2:0]  out_row_in_block;
  logic [7:0]  out_block_column;
  logic [12:0] out_block_row;
  logic        out_last_of_block;
  logic        out_last_of_image;

  // predictor state
  logic [7:0]  stripe [STORE_SIZE];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [11:0] width_reg = WIDTH_RESET;
  logic [15:0] height_reg = HEIGHT_RESET;
  block_row_t  pending_rows [$];

  int errors = 0;
  int cycles = 0;
  int pixels_sent = 0;
  int random_count = 0;
  int rows_checked = 0;
  int reg_writes = 0;
  bit in_busy = 1'b1;
  bit out_busy = 1'b1;
  int out_gap;

  stim_t directed [N_DIRECTED] = '{
    '{1'b1, 12'd0, 16'd0, 8'hFF, 1'b1},
    '{1'b0, 12'd0, 16'd0, 8'h00, 1'b1},
    '{1'b1, 12'd1, 16'd1, 8'hA5, 1'b1},
    '{1'b1, 12'd3, 16'd2, 8'h11, 1'b0},
    '{1'b0, 12'd3, 16'd2, 8'h22, 1'b0},
    '{1'b0, 12'd3, 16'd2, 8'h33, 1'b0},
    '{1'b0, 12'd3, 16'd2, 8'h44, 1'b0},
    '{1'b0, 12'd3, 16'd2, 8'h55, 1'b0},
    '{1'b0, 12'd3, 16'd2, 8'h66, 1'b0},
    '{1'b1, 12'd9, 16'd1, 8'h80, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h81, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h82, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h83, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h84, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h85, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h86, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h87, 1'b0},
    '{1'b0, 12'd9, 16'd1, 8'h88, 1'b0}
  };

  raster_to_8x8_block_padder_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_pixels   (out_row_pixels),
    .out_row_in_block (out_row_in_block),
    .out_block_column (out_block_column),
    .out_block_row    (out_block_row),
    .out_last_of_block(out_last_of_block),
    .out_last_of_image(out_last_of_image)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout with %0d block rows outstanding", $time, pending_rows.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap(input bit busy);
    if (!busy || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic int unsigned eff_width();
    int unsigned w;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > STORE_W) w = STORE_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // store one pixel and queue the block rows it completes
  task automatic predict_pixel(input logic [7:0] pix, input bit queue_rows);
    int unsigned col, row, srow, base, lastx, sy, sx;
    bit row_end, img_end;
    block_row_t r;
    col = col_pos;
    row = row_pos;
    srow = row % BLK;
    row_end = (col + 1 >= eff_width());
    img_end = (row + 1 >= eff_height());
    stripe[(srow * STORE_W + col) % STORE_SIZE] = pix;
    if (queue_rows && ((col % BLK == BLK - 1) || row_end) && ((srow == BLK - 1) || img_end)) begin
      base = col - col % BLK;
      lastx = col - base;
      for (int y = 0; y < BLK; y++) begin
        // bottom padding repeats the last valid row, right padding the last valid column
        sy = (y < srow) ? y : srow;
        for (int x = 0; x < BLK; x++) begin
          sx = (x < lastx) ? x : lastx;
          r.pixels[8*x +: 8] = stripe[(sy * STORE_W + base + sx) % STORE_SIZE];
        end
        r.row_in_block = 3'(y);
        r.block_column = 8'(col >> 3);
        r.block_row = 13'(row >> 3);
        r.last_of_block = (y == BLK - 1);
        r.last_of_image = (y == BLK - 1) && row_end && img_end;
        pending_rows.push_back(r);
      end
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = img_end ? 0 : (row + 1) & 16'hFFFF;
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic expect_flat(input logic [7:0] pix);
    block_row_t r;
    for (int y = 0; y < BLK; y++) begin
      r = '{pixels: {8{pix}}, row_in_block: 3'(y), block_column: 8'd0, block_row: 13'd0,
            last_of_block: (y == BLK - 1), last_of_image: (y == BLK - 1)};
      pending_rows.push_back(r);
    end
  endtask

  task automatic send_pixel(input logic [7:0] pix, input bit flat);
    int gap;
    gap = draw_gap(in_busy);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
    predict_pixel(pix, !flat);
    if (flat) expect_flat(pix);
    pixels_sent++;
  endtask

  // hold off the source until every queued block row is out and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic read_reg(input logic [2:0] addr, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %0d read expected %h, got %h", $time, addr, want, prdata);
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    reg_writes++;
    if (addr == ADDR_WIDTH) begin
      width_reg = word[11:0];
      read_reg(addr, {20'd0, word[11:0]});
    end else begin
      height_reg = word[15:0];
      read_reg(addr, {16'd0, word[15:0]});
    end
  endtask

  // upper data bits are junk the register has to drop
  task automatic set_size(input logic [11:0] w, input logic [15:0] h);
    drain();
    write_reg(ADDR_WIDTH, ($urandom() & 32'hFFFF_F000) | w);
    write_reg(ADDR_HEIGHT, ($urandom() & 32'hFFFF_0000) | h);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random(input int n, input bit count_random);
    repeat (n) begin
      send_pixel(8'($urandom_range(0, 255)), 1'b0);
      if (count_random) random_count++;
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(13, 20);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic field_check(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic check_row();
    block_row_t want;
    if (pending_rows.size() == 0) begin
      errors++;
      $display("%0t: block row with nothing expected, expected none, got %h row %0d",
               $time, out_row_pixels, out_row_in_block);
    end else begin
      want = pending_rows.pop_front();
      field_check("row_pixels", want.pixels, out_row_pixels);
      field_check("row_in_block", 64'(want.row_in_block), 64'(out_row_in_block));
      field_check("block_column", 64'(want.block_column), 64'(out_block_column));
      field_check("block_row", 64'(want.block_row), 64'(out_block_row));
      field_check("last_of_block", 64'(want.last_of_block), 64'(out_last_of_block));
      field_check("last_of_image", 64'(want.last_of_image), 64'(out_last_of_image));
    end
    rows_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_row();
  end

  // result side: random stall before each beat, calm and busy stretches
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      out_gap = draw_gap(out_busy);
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        repeat (out_gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (rows_checked % 32 == 0) out_busy = ($urandom_range(0, 2) != 0);
    end
  end

  initial begin
    bit first;
    int w, h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_reg(ADDR_WIDTH, {20'd0, WIDTH_RESET});
    read_reg(ADDR_HEIGHT, {16'd0, HEIGHT_RESET});
    psel <= 1'b0;
    penable <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].resize) set_size(directed[i].w, directed[i].h);
      send_pixel(directed[i].pixel, directed[i].flat);
    end

    // random images, either resized or chained after the previous one, sometimes after a drain
    first = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      in_busy = ($urandom_range(0, 3) != 0);
      if (first || $urandom_range(0, 1) == 1 ||
          eff_width() * eff_height() > RANDOM_ITEMS - random_count) begin
        w = pick_dim();
        h = pick_dim();
        // keep the last image close to the pixel budget
        if (((w == 0) ? 1 : w) * h > RANDOM_ITEMS - random_count)
          h = (RANDOM_ITEMS - random_count) / ((w == 0) ? 1 : w) + 1;
        set_size(12'(w), 16'(h));
        first = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        drain();
      end
      send_random(eff_width() * eff_height(), 1'b1);
    end

    // widest row and tallest image, cut short by resizing mid-image
    in_busy = 1'b1;
    set_size(12'hFFF, 16'd1);
    send_random(16, 1'b0);
    set_size(12'd17, 16'd1);
    send_random(1, 1'b0);
    set_size(12'd1, 16'hFFFF);
    send_random(16, 1'b0);
    set_size(12'd1, 16'd17);
    send_random(1, 1'b0);

    drain();
    $display("covered %0d pixels (%0d random) and %0d block rows, %0d register writes",
             pixels_sent, random_count, rows_checked, reg_writes);
    $display("sizes from 1x1 up to 20x20, oversized widths, mid-image resizes, %0d cycles",
             cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
